// ===== rtl/core/mpe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint ellipse package
// Shared defaults, sequencer states and multiplier operation codes.
// ----------------------------------------------------------------------------
package mpe_pkg;

   // default field widths
   localparam int COORD_BITS_DEF  = 8;
   localparam int RADIUS_BITS_DEF = 7;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_RX,
      ST_SQ_RY,
      ST_MUL_P,
      ST_START_EMIT,
      ST_STEP,
      ST_HX,
      ST_HX2,
      ST_YM,
      ST_YM2,
      ST_RR,
      ST_SW_FIN
   } state_type;

   // operand pairs for the shared multiplier
   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_RX_SQ,
      MUL_RY_SQ,
      MUL_RX2_Y,
      MUL_HX_SQ,
      MUL_RY2_PROD,
      MUL_YM_SQ,
      MUL_RX2_PROD,
      MUL_RX2_RY2
   } mul_op_type;

endpackage

// ===== rtl/core/mpe_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint ellipse shared multiplier
// Operand select and one unsigned multiply used by every setup step.
// ----------------------------------------------------------------------------
module mpe_mul #(
   parameter int RADIUS_BITS = mpe_pkg::RADIUS_BITS_DEF
) (
   input  mpe_pkg::mul_op_type          op,
   input  logic [2*RADIUS_BITS-1:0]     rx2,
   input  logic [2*RADIUS_BITS-1:0]     ry2,
   input  logic [2*RADIUS_BITS+3:0]     prod,
   input  logic [RADIUS_BITS:0]         x_off,
   input  logic [RADIUS_BITS:0]         y_off,
   output logic [4*RADIUS_BITS+7:0]     product
);
   import mpe_pkg::*;

   localparam int MW    = 2 * RADIUS_BITS + 4;
   localparam int OFF_W = RADIUS_BITS + 1;

   logic [MW-1:0]    op_a;
   logic [MW-1:0]    op_b;
   logic [OFF_W:0]   hx;
   logic [OFF_W-1:0] ym;
   logic [MW-1:0]    rx2_ext;
   logic [MW-1:0]    ry2_ext;
   logic [MW-1:0]    y_ext;
   logic [MW-1:0]    hx_ext;
   logic [MW-1:0]    ym_ext;

   // half-step terms: 2x+1 and y-1
   assign hx = {x_off, 1'b1};
   assign ym = y_off - {{(OFF_W-1){1'b0}}, 1'b1};

   assign rx2_ext = {4'b0000, rx2};
   assign ry2_ext = {4'b0000, ry2};
   assign y_ext   = {{(MW-OFF_W){1'b0}}, y_off};
   assign hx_ext  = {{(MW-OFF_W-1){1'b0}}, hx};
   assign ym_ext  = {{(MW-OFF_W){1'b0}}, ym};

   // operand select
   always_comb begin
      case (op)
         MUL_RX_SQ: begin
            op_a = rx2_ext;
            op_b = rx2_ext;
         end
         MUL_RY_SQ: begin
            op_a = y_ext;
            op_b = y_ext;
         end
         MUL_RX2_Y: begin
            op_a = rx2_ext;
            op_b = y_ext;
         end
         MUL_HX_SQ: begin
            op_a = hx_ext;
            op_b = hx_ext;
         end
         MUL_RY2_PROD: begin
            op_a = ry2_ext;
            op_b = prod;
         end
         MUL_YM_SQ: begin
            op_a = ym_ext;
            op_b = ym_ext;
         end
         MUL_RX2_PROD: begin
            op_a = rx2_ext;
            op_b = prod;
         end
         MUL_RX2_RY2: begin
            op_a = rx2_ext;
            op_b = ry2_ext;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign product = op_a * op_b;

endmodule

// ===== rtl/core/midpoint_ellipse_point_generator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint ellipse point generator
// One quadrant of an axis-aligned ellipse, mirrored to columns and rows.
// ----------------------------------------------------------------------------
// A start transfer loads centre and radii. Three products (Rx^2, Ry^2,
// Rx^2*Ry) run one per cycle through the single shared multiplier, and the
// region 1 decision is formed beside the last one. A final state rounds the
// decision and loads the point once the output register is free. The next
// transfer can be taken in the cycle after that. A step transfer makes one
// add/compare update and loads its point once the output register is free.
// The step that leaves region 1 first passes the compare that finds region 1
// finished, five multiplies on the same multiplier and the region 2 setup.
// The input side is taken only in the idle state; a result waiting in the
// output register does not block the next transfer, and the sequencer holds
// its result until that register is free. The point whose y offset is zero
// is flagged last; step transfers after it return nothing.
// ----------------------------------------------------------------------------
module midpoint_ellipse_point_generator_core #(
   parameter int COORD_BITS  = mpe_pkg::COORD_BITS_DEF,
   parameter int RADIUS_BITS = mpe_pkg::RADIUS_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_start_req,
   input  logic [COORD_BITS-1:0]        req_center_x,
   input  logic [COORD_BITS-1:0]        req_center_y,
   input  logic [RADIUS_BITS-1:0]       req_radius_x,
   input  logic [RADIUS_BITS-1:0]       req_radius_y,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [COORD_BITS+1:0] rsp_col_right,
   output logic signed [COORD_BITS+1:0] rsp_col_left,
   output logic signed [COORD_BITS+1:0] rsp_row_top,
   output logic signed [COORD_BITS+1:0] rsp_row_bottom,
   output logic                         rsp_last_point
);
   import mpe_pkg::*;

   localparam int OUT_W  = COORD_BITS + 2;
   localparam int OFF_W  = RADIUS_BITS + 1;
   localparam int SQ_W   = 2 * RADIUS_BITS;
   localparam int MW     = 2 * RADIUS_BITS + 4;
   localparam int PW     = 2 * MW;
   localparam int TERM_W = 3 * RADIUS_BITS + 3;
   localparam int DEC_W  = 5 * RADIUS_BITS + 5;
   localparam int WIDE_W = OUT_W + OFF_W;

   // sequencer and walk state
   state_type                 state_ff, state_in;
   logic                      running_ff, running_in;
   logic                      region2_ff, region2_in;
   logic [OFF_W-1:0]          x_ff, x_in;
   logic [OFF_W-1:0]          y_ff, y_in;
   logic [TERM_W-1:0]         x_term_ff, x_term_in;
   logic [TERM_W-1:0]         y_term_ff, y_term_in;
   logic signed [DEC_W-1:0]   dec_ff, dec_in;
   logic signed [DEC_W-1:0]   acc_ff, acc_in;
   logic [SQ_W-1:0]           rx2_ff, rx2_in;
   logic [SQ_W-1:0]           ry2_ff, ry2_in;
   logic [MW-1:0]             prod_ff, prod_in;
   logic [COORD_BITS-1:0]     cx_ff, cx_in;
   logic [COORD_BITS-1:0]     cy_ff, cy_in;

   // output register
   logic                      out_valid_ff, out_valid_in;
   logic [OUT_W-1:0]          col_right_ff, col_right_in;
   logic [OUT_W-1:0]          col_left_ff, col_left_in;
   logic [OUT_W-1:0]          row_top_ff, row_top_in;
   logic [OUT_W-1:0]          row_bottom_ff, row_bottom_in;
   logic                      last_ff, last_in;

   // shared multiplier
   mul_op_type                mul_op;
   logic [PW-1:0]             product;
   logic signed [DEC_W-1:0]   prod_dec;

   // step arithmetic
   logic                      out_free;
   logic                      emit;
   logic [OFF_W-1:0]          emit_x;
   logic [OFF_W-1:0]          emit_y;
   logic [OFF_W-1:0]          x_inc;
   logic [OFF_W-1:0]          y_dec;
   logic [TERM_W-1:0]         x_term_inc;
   logic [TERM_W-1:0]         y_term_dec;
   logic signed [DEC_W-1:0]   ry2_dec;
   logic signed [DEC_W-1:0]   rx2_dec;
   logic signed [DEC_W-1:0]   x_term_inc_dec;
   logic signed [DEC_W-1:0]   y_term_dec_dec;
   logic signed [DEC_W-1:0]   acc_adj;
   logic signed [DEC_W-1:0]   acc_quarter;
   logic [WIDE_W-1:0]         cx_wide;
   logic [WIDE_W-1:0]         cy_wide;
   logic [WIDE_W-1:0]         ex_wide;
   logic [WIDE_W-1:0]         ey_wide;
   logic [WIDE_W-1:0]         col_r_wide;
   logic [WIDE_W-1:0]         col_l_wide;
   logic [WIDE_W-1:0]         row_t_wide;
   logic [WIDE_W-1:0]         row_b_wide;

   mpe_mul #(
      .RADIUS_BITS (RADIUS_BITS)
   ) u_mul (
      .op      (mul_op),
      .rx2     (rx2_ff),
      .ry2     (ry2_ff),
      .prod    (prod_ff),
      .x_off   (x_ff),
      .y_off   (y_ff),
      .product (product)
   );

   assign prod_dec = {{(DEC_W-PW){1'b0}}, product};

   // incremental terms
   assign x_inc      = x_ff + {{(OFF_W-1){1'b0}}, 1'b1};
   assign y_dec      = y_ff - {{(OFF_W-1){1'b0}}, 1'b1};
   assign x_term_inc = x_term_ff + {{(TERM_W-SQ_W-1){1'b0}}, ry2_ff, 1'b0};
   assign y_term_dec = y_term_ff - {{(TERM_W-SQ_W-1){1'b0}}, rx2_ff, 1'b0};
   assign ry2_dec        = {{(DEC_W-SQ_W){1'b0}}, ry2_ff};
   assign rx2_dec        = {{(DEC_W-SQ_W){1'b0}}, rx2_ff};
   assign x_term_inc_dec = {{(DEC_W-TERM_W){1'b0}}, x_term_inc};
   assign y_term_dec_dec = {{(DEC_W-TERM_W){1'b0}}, y_term_dec};

   // quarter units to whole units, truncating toward zero
   assign acc_adj     = acc_ff + {{(DEC_W-2){1'b0}}, {2{acc_ff[DEC_W-1]}}};
   assign acc_quarter = {{2{acc_adj[DEC_W-1]}}, acc_adj[DEC_W-1:2]};

   // mirrored coordinates, wrapped to the output width
   assign cx_wide    = {{(WIDE_W-COORD_BITS){1'b0}}, cx_ff};
   assign cy_wide    = {{(WIDE_W-COORD_BITS){1'b0}}, cy_ff};
   assign ex_wide    = {{OUT_W{1'b0}}, emit_x};
   assign ey_wide    = {{OUT_W{1'b0}}, emit_y};
   assign col_r_wide = cx_wide + ex_wide;
   assign col_l_wide = cx_wide - ex_wide;
   assign row_t_wide = cy_wide - ey_wide;
   assign row_b_wide = cy_wide + ey_wide;

   assign out_free = !out_valid_ff || rsp_ready;

   // multiplier operand pair for each setup state
   always_comb begin
      case (state_ff)
         ST_SQ_RX: mul_op = MUL_RX_SQ;
         ST_SQ_RY: mul_op = MUL_RY_SQ;
         ST_MUL_P: mul_op = MUL_RX2_Y;
         ST_HX:    mul_op = MUL_HX_SQ;
         ST_HX2:   mul_op = MUL_RY2_PROD;
         ST_YM:    mul_op = MUL_YM_SQ;
         ST_YM2:   mul_op = MUL_RX2_PROD;
         ST_RR:    mul_op = MUL_RX2_RY2;
         default:  mul_op = MUL_NONE;
      endcase
   end

   // sequencer: next state, datapath updates, result load
   always_comb begin
      state_in     = state_ff;
      running_in   = running_ff;
      region2_in   = region2_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      x_term_in    = x_term_ff;
      y_term_in    = y_term_ff;
      dec_in       = dec_ff;
      acc_in       = acc_ff;
      rx2_in       = rx2_ff;
      ry2_in       = ry2_ff;
      prod_in      = prod_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      req_ready    = 1'b0;
      emit         = 1'b0;
      emit_x       = x_ff;
      emit_y       = y_ff;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_start_req) begin
                  // rx is parked in rx2 until it is squared
                  cx_in      = req_center_x;
                  cy_in      = req_center_y;
                  rx2_in     = {{RADIUS_BITS{1'b0}}, req_radius_x};
                  x_in       = '0;
                  y_in       = {1'b0, req_radius_y};
                  x_term_in  = '0;
                  region2_in = 1'b0;
                  running_in = 1'b1;
                  state_in   = ST_SQ_RX;
               end else if (running_ff) begin
                  state_in = ST_STEP;
               end
            end
         end
         ST_SQ_RX: begin
            rx2_in   = product[SQ_W-1:0];
            state_in = ST_SQ_RY;
         end
         ST_SQ_RY: begin
            ry2_in   = product[SQ_W-1:0];
            state_in = ST_MUL_P;
         end
         ST_MUL_P: begin
            // 4*Ry^2 - 4*Rx^2*Ry + Rx^2 in quarter units
            y_term_in = {product[TERM_W-2:0], 1'b0};
            acc_in    = (ry2_dec <<< 2) - (prod_dec <<< 2) + rx2_dec;
            state_in  = ST_START_EMIT;
         end
         ST_START_EMIT: begin
            if (out_free) begin
               dec_in     = acc_quarter;
               emit       = 1'b1;
               running_in = (y_ff != '0);
               state_in   = ST_IDLE;
            end
         end
         ST_STEP: begin
            if (!region2_ff && (x_term_ff < y_term_ff)) begin
               // region 1: x always advances, y on a non-negative decision
               if (out_free) begin
                  x_in      = x_inc;
                  x_term_in = x_term_inc;
                  emit_x    = x_inc;
                  if (dec_ff[DEC_W-1]) begin
                     dec_in = dec_ff + ry2_dec + x_term_inc_dec;
                  end else begin
                     y_in      = y_dec;
                     y_term_in = y_term_dec;
                     emit_y    = y_dec;
                     dec_in    = dec_ff + ry2_dec + x_term_inc_dec - y_term_dec_dec;
                  end
                  emit       = 1'b1;
                  running_in = (emit_y != '0);
                  state_in   = ST_IDLE;
               end
            end else if (!region2_ff) begin
               state_in = ST_HX;
            end else if (y_ff == '0) begin
               running_in = 1'b0;
               state_in   = ST_IDLE;
            end else if (out_free) begin
               // region 2: y always advances, x on a non-positive decision
               y_in      = y_dec;
               y_term_in = y_term_dec;
               emit_y    = y_dec;
               if (!dec_ff[DEC_W-1] && (dec_ff != '0)) begin
                  dec_in = dec_ff + rx2_dec - y_term_dec_dec;
               end else begin
                  x_in      = x_inc;
                  x_term_in = x_term_inc;
                  emit_x    = x_inc;
                  dec_in    = dec_ff + rx2_dec - y_term_dec_dec + x_term_inc_dec;
               end
               emit       = 1'b1;
               running_in = (y_dec != '0);
               state_in   = ST_IDLE;
            end
         end
         ST_HX: begin
            prod_in  = product[MW-1:0];
            state_in = ST_HX2;
         end
         ST_HX2: begin
            acc_in   = prod_dec;
            state_in = ST_YM;
         end
         ST_YM: begin
            prod_in  = product[MW-1:0];
            state_in = ST_YM2;
         end
         ST_YM2: begin
            acc_in   = acc_ff + (prod_dec <<< 2);
            state_in = ST_RR;
         end
         ST_RR: begin
            acc_in   = acc_ff - (prod_dec <<< 2);
            state_in = ST_SW_FIN;
         end
         ST_SW_FIN: begin
            dec_in     = acc_quarter;
            region2_in = 1'b1;
            state_in   = ST_STEP;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register next values
   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_ready;
      col_right_in  = col_right_ff;
      col_left_in   = col_left_ff;
      row_top_in    = row_top_ff;
      row_bottom_in = row_bottom_ff;
      last_in       = last_ff;
      if (emit) begin
         out_valid_in  = 1'b1;
         col_right_in  = col_r_wide[OUT_W-1:0];
         col_left_in   = col_l_wide[OUT_W-1:0];
         row_top_in    = row_t_wide[OUT_W-1:0];
         row_bottom_in = row_b_wide[OUT_W-1:0];
         last_in       = (emit_y == '0);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         running_ff   <= 1'b0;
         region2_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         region2_ff   <= region2_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      y_ff          <= y_in;
      x_term_ff     <= x_term_in;
      y_term_ff     <= y_term_in;
      dec_ff        <= dec_in;
      acc_ff        <= acc_in;
      rx2_ff        <= rx2_in;
      ry2_ff        <= ry2_in;
      prod_ff       <= prod_in;
      cx_ff         <= cx_in;
      cy_ff         <= cy_in;
      col_right_ff  <= col_right_in;
      col_left_ff   <= col_left_in;
      row_top_ff    <= row_top_in;
      row_bottom_ff <= row_bottom_in;
      last_ff       <= last_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_col_right  = col_right_ff;
   assign rsp_col_left   = col_left_ff;
   assign rsp_row_top    = row_top_ff;
   assign rsp_row_bottom = row_bottom_ff;
   assign rsp_last_point = last_ff;

endmodule

// ===== rtl/core/mpe_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint ellipse port checker
// Port-level properties of the point generator, bound to the top level.
// ----------------------------------------------------------------------------
module mpe_checker #(
   parameter int COORD_BITS  = mpe_pkg::COORD_BITS_DEF
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_start_req,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic signed [COORD_BITS+1:0] rsp_col_right,
   input logic signed [COORD_BITS+1:0] rsp_col_left,
   input logic signed [COORD_BITS+1:0] rsp_row_top,
   input logic signed [COORD_BITS+1:0] rsp_row_bottom,
   input logic                         rsp_last_point
);
   import mpe_pkg::*;

   // a stalled response stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before transfer");

   // a stalled response keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_col_right) && $stable(rsp_col_left)
         && $stable(rsp_row_top) && $stable(rsp_row_bottom) && $stable(rsp_last_point))
      else $error("response payload changed while stalled");

   // the last point sits on the horizontal axis
   a_last_on_axis: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_point |-> rsp_row_top == rsp_row_bottom)
      else $error("last point with nonzero y offset");

   // a start transfer occupies the multiplier for the next cycle
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_start_req |=> !req_ready)
      else $error("request taken during start setup");

   // no response straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind midpoint_ellipse_point_generator_core mpe_checker #(
   .COORD_BITS  (COORD_BITS)
) u_mpe_checker (.*);

// ===== tb/midpoint_ellipse_point_generator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint ellipse point generator testbench
// Drives start and step transfers into the core and checks every returned
// point against a cycle-free model of the midpoint walk. Covers degenerate
// radii, restarts mid-walk, steps while idle, coordinate extremes and random
// ellipses, with random stalls on both channels and a full-rate tail.
// ----------------------------------------------------------------------------
module midpoint_ellipse_point_generator_core_tb;

   localparam int CW         = mpe_pkg::COORD_BITS_DEF;
   localparam int RW         = mpe_pkg::RADIUS_BITS_DEF;
   localparam int OW         = CW + 2;
   localparam int QUIET_MAX  = 2000;
   localparam int DRAIN_WAIT = 20;

   typedef struct {
      logic signed [OW-1:0] col_right;
      logic signed [OW-1:0] col_left;
      logic signed [OW-1:0] row_top;
      logic signed [OW-1:0] row_bottom;
      logic                 last_point;
   } point_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_start_req;
   logic [CW-1:0]        req_center_x;
   logic [CW-1:0]        req_center_y;
   logic [RW-1:0]        req_radius_x;
   logic [RW-1:0]        req_radius_y;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b1;
   logic signed [OW-1:0] rsp_col_right;
   logic signed [OW-1:0] rsp_col_left;
   logic signed [OW-1:0] rsp_row_top;
   logic signed [OW-1:0] rsp_row_bottom;
   logic                 rsp_last_point;

   // expected points, oldest first
   point_type pending_points[$];
   int     mismatch_count = 0;
   int     items_sent;
   int     quiet_cycles = 0;
   int     stall_left = 0;
   bit     idling_on;

   // walk state of the ellipse model
   longint walk_x;
   longint walk_y;
   longint slope_x;
   longint slope_y;
   longint decision_val;
   bit     in_region_two;
   bit     ellipse_active;
   longint ctr_col;
   longint ctr_row;
   longint rx_sq;
   longint ry_sq;

   midpoint_ellipse_point_generator_core u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_start_req  (req_start_req),
      .req_center_x   (req_center_x),
      .req_center_y   (req_center_y),
      .req_radius_x   (req_radius_x),
      .req_radius_y   (req_radius_y),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_col_right  (rsp_col_right),
      .rsp_col_left   (rsp_col_left),
      .rsp_row_top    (rsp_row_top),
      .rsp_row_bottom (rsp_row_bottom),
      .rsp_last_point (rsp_last_point)
   );

   // clock
   always #6 clock = ~clock;

   // ---------------------------------------------------------------------
   // Ellipse model
   // ---------------------------------------------------------------------

   // mirrored point at the current offsets; y offset zero ends the walk
   function automatic point_type current_point();
      point_type pt;
      pt.col_right  = OW'(ctr_col + walk_x);
      pt.col_left   = OW'(ctr_col - walk_x);
      pt.row_top    = OW'(ctr_row - walk_y);
      pt.row_bottom = OW'(ctr_row + walk_y);
      pt.last_point = (walk_y == 0);
      if (walk_y == 0)
         ellipse_active = 1'b0;
      return pt;
   endfunction

   // advance the walk by one transfer; returns 1 when a point comes out
   function automatic bit next_ellipse_point(input bit start, input logic [CW-1:0] cx,
                                             input logic [CW-1:0] cy,
                                             input logic [RW-1:0] rx,
                                             input logic [RW-1:0] ry,
                                             output point_type pt);
      longint rxl;
      longint ryl;
      longint hx;
      longint ym;
      rxl = longint'(rx);
      ryl = longint'(ry);
      // start: load ellipse, region 1 decision formed in quarter units, kept in whole units
      if (start) begin
         ctr_col        = longint'(cx);
         ctr_row        = longint'(cy);
         rx_sq          = rxl * rxl;
         ry_sq          = ryl * ryl;
         walk_x         = 0;
         walk_y         = ryl;
         slope_x        = 0;
         slope_y        = 2 * rx_sq * ryl;
         decision_val   = (4 * ry_sq - 4 * rx_sq * ryl + rx_sq) / 4;
         in_region_two  = 1'b0;
         ellipse_active = 1'b1;
         pt = current_point();
         return 1'b1;
      end
      if (!ellipse_active)
         return 1'b0;
      // region 1 while the x slope stays below the y slope
      if (!in_region_two) begin
         if (slope_x < slope_y) begin
            walk_x++;
            slope_x += 2 * ry_sq;
            if (decision_val < 0) begin
               decision_val += ry_sq + slope_x;
            end else begin
               walk_y--;
               slope_y -= 2 * rx_sq;
               decision_val += ry_sq + slope_x - slope_y;
            end
            pt = current_point();
            return 1'b1;
         end
         // switch: region 2 decision at (x + 1/2, y - 1)
         hx = 2 * walk_x + 1;
         ym = walk_y - 1;
         decision_val  = (ry_sq * hx * hx + 4 * rx_sq * ym * ym - 4 * rx_sq * ry_sq) / 4;
         in_region_two = 1'b1;
      end
      if (walk_y <= 0) begin
         ellipse_active = 1'b0;
         return 1'b0;
      end
      // region 2
      walk_y--;
      slope_y -= 2 * rx_sq;
      if (decision_val > 0) begin
         decision_val += rx_sq - slope_y;
      end else begin
         walk_x++;
         slope_x += 2 * ry_sq;
         decision_val += rx_sq - slope_y + slope_x;
      end
      pt = current_point();
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // one transfer; entered and left at a falling edge, valid left high unless a random gap follows
   task automatic send_item(input bit start, input logic [CW-1:0] cx,
                            input logic [CW-1:0] cy, input logic [RW-1:0] rx,
                            input logic [RW-1:0] ry);
      point_type pt;
      req_valid     = 1'b1;
      req_start_req = start;
      req_center_x  = cx;
      req_center_y  = cy;
      req_radius_x  = rx;
      req_radius_y  = ry;
      do
         @(posedge clock);
      while (!req_ready);
      if (next_ellipse_point(start, cx, cy, rx, ry, pt))
         pending_points.push_back(pt);
      items_sent++;
      @(negedge clock);
      // random sender gap with junk payload
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid     = 1'b0;
         req_start_req = 1'($urandom_range(0, 1));
         req_center_x  = CW'($urandom_range(0, 255));
         req_center_y  = CW'($urandom_range(0, 255));
         req_radius_x  = RW'($urandom_range(0, 127));
         req_radius_y  = RW'($urandom_range(0, 127));
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   endtask

   // step with random, ignored payload
   task automatic send_step();
      send_item(1'b0, CW'($urandom_range(0, 255)), CW'($urandom_range(0, 255)),
                RW'($urandom_range(0, 127)), RW'($urandom_range(0, 127)));
   endtask

   // start an ellipse, walk it (or break off), then a few spare steps
   task automatic run_ellipse(input logic [CW-1:0] cx, input logic [CW-1:0] cy,
                              input logic [RW-1:0] rx, input logic [RW-1:0] ry,
                              input int max_steps, input int spare_steps);
      int n;
      n = 0;
      send_item(1'b1, cx, cy, rx, ry);
      while (ellipse_active && n < max_steps) begin
         send_step();
         n++;
      end
      repeat (spare_steps) send_step();
   endtask

   // hold the sender off until every point is back
   task automatic drain_points();
      req_valid = 1'b0;
      while (pending_points.size() != 0)
         @(posedge clock);
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // steps out of reset give nothing
   task automatic test_idle_steps();
      send_step();
      send_step();
   endtask

   // zero radii: single point, column walk, and a zero Ry that ends at its first point
   task automatic test_degenerate_radii();
      run_ellipse(8'd0, 8'd0, 7'd0, 7'd0, 1000, 1);
      run_ellipse(8'd255, 8'd255, 7'd0, 7'd5, 1000, 1);
      run_ellipse(8'd17, 8'd200, 7'd6, 7'd0, 1000, 1);
   endtask

   // largest radii at both corners, broken off by fresh starts
   task automatic test_restart_extremes();
      run_ellipse(8'd255, 8'd255, 7'd127, 7'd127, 3, 0);
      run_ellipse(8'd0, 8'd0, 7'd127, 7'd1, 2, 0);
      run_ellipse(8'd128, 8'd64, 7'd2, 7'd3, 1000, 1);
   endtask

   // pause mid-walk until the pipe is empty, then finish the walk
   task automatic test_drain_pause();
      run_ellipse(CW'($urandom_range(0, 255)), CW'($urandom_range(0, 255)),
                  7'd9, 7'd7, 3, 0);
      drain_points();
      while (ellipse_active)
         send_step();
   endtask

   // random ellipses, mostly small, some full size, some broken off
   task automatic test_random_ellipses(input int item_goal);
      logic [RW-1:0] rx;
      logic [RW-1:0] ry;
      int            max_steps;
      int            spare;
      while (items_sent < item_goal) begin
         if ($urandom_range(0, 31) == 0) begin
            rx = RW'($urandom_range(0, 127));
            ry = RW'($urandom_range(0, 127));
         end else begin
            rx = RW'($urandom_range(0, 20));
            ry = RW'($urandom_range(0, 20));
         end
         if ($urandom_range(0, 7) == 0)
            max_steps = $urandom_range(0, 30);
         else if ((rx > 40 || ry > 40) && $urandom_range(0, 1) == 0)
            max_steps = $urandom_range(0, 60);
         else
            max_steps = 1000;
         spare = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
         run_ellipse(CW'($urandom_range(0, 255)), CW'($urandom_range(0, 255)), rx, ry,
                     max_steps, spare);
      end
   endtask

   // ---------------------------------------------------------------------
   // Response side
   // ---------------------------------------------------------------------

   // receiver stalls in bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready = 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 11);
         rsp_ready  = 1'b0;
      end else begin
         rsp_ready = 1'b1;
      end
   end

   // compare each returned point with the oldest expected one
   always @(posedge clock) begin
      point_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_points.size() == 0) begin
            $error("unexpected point: col_right %0d row_top %0d last %0b",
                   rsp_col_right, rsp_row_top, rsp_last_point);
            mismatch_count++;
         end else begin
            want = pending_points.pop_front();
            if (rsp_col_right !== want.col_right) begin
               $error("col_right: expected %0d, got %0d", want.col_right, rsp_col_right);
               mismatch_count++;
            end
            if (rsp_col_left !== want.col_left) begin
               $error("col_left: expected %0d, got %0d", want.col_left, rsp_col_left);
               mismatch_count++;
            end
            if (rsp_row_top !== want.row_top) begin
               $error("row_top: expected %0d, got %0d", want.row_top, rsp_row_top);
               mismatch_count++;
            end
            if (rsp_row_bottom !== want.row_bottom) begin
               $error("row_bottom: expected %0d, got %0d", want.row_bottom, rsp_row_bottom);
               mismatch_count++;
            end
            if (rsp_last_point !== want.last_point) begin
               $error("last_point: expected %0b, got %0b", want.last_point, rsp_last_point);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_MAX) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_start_req  = 1'b0;
      req_center_x   = '0;
      req_center_y   = '0;
      req_radius_x   = '0;
      req_radius_y   = '0;
      items_sent     = 0;
      idling_on      = 1'b1;
      ellipse_active = 1'b0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      test_idle_steps();
      test_degenerate_radii();
      test_restart_extremes();
      test_random_ellipses(700);
      test_drain_pause();
      test_random_ellipses(1400);
      // full rate tail
      idling_on = 1'b0;
      test_random_ellipses(1560);

      req_valid = 1'b0;
      while (pending_points.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== midpoint_ellipse_point_generator_core.f =====
rtl/core/mpe_pkg.sv
rtl/core/mpe_mul.sv
rtl/core/midpoint_ellipse_point_generator_core.sv
rtl/core/mpe_checker.sv
tb/midpoint_ellipse_point_generator_core_tb.sv
